// ===== design/lbsm_pkg.sv =====
// Shared types and constants for the low battery shutdown monitor.
package lbsm_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned TICKS_W   = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = TICKS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMERGENCY_LEVEL        = 3'd0,
    REG_LOW_LEVEL              = 3'd1,
    REG_LOW_VOLTAGE_TICKS      = 3'd2,
    REG_EARLY_TICKS            = 3'd3,
    REG_BATTERY_SHUTDOWN_TICKS = 3'd4,
    REG_WARNING_TICKS          = 3'd5
  } cfg_idx_t;

  localparam logic [LEVEL_W-1:0] EMERGENCY_LEVEL_RST        = 16'd2487;
  localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST              = 16'd2648;
  localparam logic [TICKS_W-1:0] LOW_VOLTAGE_TICKS_RST      = 20'd9000;
  localparam logic [TICKS_W-1:0] EARLY_TICKS_RST            = 20'd200;
  localparam logic [TICKS_W-1:0] BATTERY_SHUTDOWN_TICKS_RST = 20'd2000;
  localparam logic [TICKS_W-1:0] WARNING_TICKS_RST          = 20'd50000;

  typedef struct packed {
    logic [LEVEL_W-1:0] emergency_level;
    logic [LEVEL_W-1:0] low_level;
    logic [TICKS_W-1:0] low_voltage_ticks;
    logic [TICKS_W-1:0] early_ticks;
    logic [TICKS_W-1:0] battery_shutdown_ticks;
    logic [TICKS_W-1:0] warning_ticks;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] vmain_sample;
    logic               charger_present;
    logic               robot_unpowered;
    logic               battery_full_clear;
  } in_item_t;

  typedef struct packed {
    logic stop_request;
    logic battery_low;
    logic battery_shutdown;
  } out_item_t;

endpackage

// ===== design/lbsm_tracker.sv =====
// Battery state counters and flags with the per-tick update.
module lbsm_tracker #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  lbsm_pkg::cfg_t    cfg,
  input  logic              step,
  input  lbsm_pkg::in_item_t item,
  output lbsm_pkg::out_item_t res
);

  localparam int unsigned CW = (COUNT_BITS > lbsm_pkg::TICKS_W) ?
                               COUNT_BITS : lbsm_pkg::TICKS_W;

  logic [COUNT_BITS-1:0] emergency_count, emergency_count_next;
  logic [COUNT_BITS-1:0] boot_window_count, boot_window_count_next;
  logic [COUNT_BITS-1:0] low_timer, low_timer_next;
  logic [COUNT_BITS-1:0] warning_count, warning_count_next;
  logic                  low_flag, low_flag_next;
  logic                  shutdown_flag, shutdown_flag_next;
  logic                  stop;
  logic                  below_em;
  logic                  below_low;
  logic [COUNT_BITS-1:0] warning_dec;

  assign below_em    = item.vmain_sample < cfg.emergency_level;
  assign below_low   = item.vmain_sample < cfg.low_level;
  assign warning_dec = warning_count - COUNT_BITS'(1);

  always_comb begin
    emergency_count_next   = emergency_count;
    boot_window_count_next = boot_window_count;
    low_timer_next         = low_timer;
    warning_count_next     = warning_count;
    low_flag_next          = low_flag;
    shutdown_flag_next     = shutdown_flag;
    stop                   = 1'b0;
    if (below_em) begin
      if (emergency_count != '0) begin
        emergency_count_next = emergency_count - COUNT_BITS'(1);
        stop = (emergency_count == COUNT_BITS'(1));
      end
    end else begin
      emergency_count_next = COUNT_BITS'(cfg.early_ticks);
      if (item.charger_present) begin
        shutdown_flag_next     = 1'b0;
        boot_window_count_next = COUNT_BITS'(cfg.early_ticks);
        if (CW'(warning_count) < CW'(cfg.warning_ticks)) begin
          warning_count_next = warning_count + COUNT_BITS'(1);
        end else if (CW'(low_timer) < CW'(cfg.low_voltage_ticks)) begin
          low_timer_next = low_timer + COUNT_BITS'(1);
        end else begin
          low_flag_next = 1'b0;
        end
      end else if (CW'(boot_window_count) < CW'(cfg.early_ticks)) begin
        if (below_low) begin
          low_flag_next = 1'b1;
        end
        boot_window_count_next = boot_window_count + COUNT_BITS'(1);
      end else if (low_flag) begin
        if (warning_count == '0) begin
          stop = 1'b1;
        end else begin
          warning_count_next = warning_dec;
          if (CW'(warning_dec) < CW'(cfg.battery_shutdown_ticks)) begin
            shutdown_flag_next = 1'b1;
          end
        end
      end else if (below_low) begin
        if (low_timer != '0) begin
          low_timer_next = low_timer - COUNT_BITS'(1);
        end
        if (low_timer <= COUNT_BITS'(1)) begin
          low_flag_next = 1'b1;
        end
      end else begin
        low_timer_next     = COUNT_BITS'(cfg.low_voltage_ticks);
        warning_count_next = COUNT_BITS'(cfg.warning_ticks);
      end
    end
    if (item.robot_unpowered) begin
      boot_window_count_next = '0;
    end
    if (item.battery_full_clear) begin
      low_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emergency_count   <= COUNT_BITS'(lbsm_pkg::EARLY_TICKS_RST);
      boot_window_count <= '0;
      low_timer         <= COUNT_BITS'(lbsm_pkg::LOW_VOLTAGE_TICKS_RST);
      warning_count     <= COUNT_BITS'(lbsm_pkg::WARNING_TICKS_RST);
      low_flag          <= 1'b0;
      shutdown_flag     <= 1'b0;
    end else if (step) begin
      emergency_count   <= emergency_count_next;
      boot_window_count <= boot_window_count_next;
      low_timer         <= low_timer_next;
      warning_count     <= warning_count_next;
      low_flag          <= low_flag_next;
      shutdown_flag     <= shutdown_flag_next;
    end
  end

  assign res.stop_request     = stop;
  assign res.battery_low      = low_flag_next;
  assign res.battery_shutdown = shutdown_flag_next;

`ifndef SYNTH
  a_stop_cause: assert property (@(posedge clk) disable iff (rst)
    step && stop && !below_em |-> low_flag && warning_count == '0 && !item.charger_present)
    else $error("stop request without empty warning countdown");

  a_full_clear: assert property (@(posedge clk) disable iff (rst)
    step && item.battery_full_clear |=> !low_flag)
    else $error("low flag survived full-battery clear");

  a_unpowered: assert property (@(posedge clk) disable iff (rst)
    step && item.robot_unpowered |=> boot_window_count == '0)
    else $error("boot window not cleared");

  a_emerg_hold: assert property (@(posedge clk) disable iff (rst)
    step && below_em |=> shutdown_flag == $past(shutdown_flag)
                         && warning_count == $past(warning_count))
    else $error("warning state moved during emergency filtering");
`endif

endmodule

// ===== design/low_battery_shutdown_monitor.sv =====
// Top level of the low battery shutdown monitor: config, input and result registers.
// One transfer in is one tick: a voltage code with the charger and caller flags. Every
// tick gives exactly one result (stop request, low flag, shutdown flag). The block takes
// one tick per clock cycle while the result side does not stall; the input register and
// the result register are the two stages, with the counter update done combinationally
// between them. Configuration registers take effect on the next tick and do not reload
// the running counters; only reset does that.
module low_battery_shutdown_monitor #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lbsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lbsm_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lbsm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lbsm_pkg::out_item_t                 out_data
);

  lbsm_pkg::cfg_t      cfg;
  lbsm_pkg::in_item_t  in_q;
  lbsm_pkg::out_item_t res;
  logic                in_full;
  logic                advance;
  logic                in_take;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.emergency_level        <= lbsm_pkg::EMERGENCY_LEVEL_RST;
      cfg.low_level              <= lbsm_pkg::LOW_LEVEL_RST;
      cfg.low_voltage_ticks      <= lbsm_pkg::LOW_VOLTAGE_TICKS_RST;
      cfg.early_ticks            <= lbsm_pkg::EARLY_TICKS_RST;
      cfg.battery_shutdown_ticks <= lbsm_pkg::BATTERY_SHUTDOWN_TICKS_RST;
      cfg.warning_ticks          <= lbsm_pkg::WARNING_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (lbsm_pkg::cfg_idx_t'(cfg_index))
        lbsm_pkg::REG_EMERGENCY_LEVEL: begin
          cfg.emergency_level <= cfg_wr_data[lbsm_pkg::LEVEL_W-1:0];
        end
        lbsm_pkg::REG_LOW_LEVEL: begin
          cfg.low_level <= cfg_wr_data[lbsm_pkg::LEVEL_W-1:0];
        end
        lbsm_pkg::REG_LOW_VOLTAGE_TICKS: begin
          cfg.low_voltage_ticks <= cfg_wr_data;
        end
        lbsm_pkg::REG_EARLY_TICKS: begin
          cfg.early_ticks <= cfg_wr_data;
        end
        lbsm_pkg::REG_BATTERY_SHUTDOWN_TICKS: begin
          cfg.battery_shutdown_ticks <= cfg_wr_data;
        end
        lbsm_pkg::REG_WARNING_TICKS: begin
          cfg.warning_ticks <= cfg_wr_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_take || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= in_data;
    end
  end

  lbsm_tracker #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tracker (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .item (in_q),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the low battery shutdown monitor: predictor, driver and monitor.
module tb_top;

  localparam int unsigned CNT_W          = 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam logic [lbsm_pkg::TICKS_W-1:0] TICKS_MAX = '1;

  typedef enum int {BAND_EMERG, BAND_LOW, BAND_OK, BAND_CHARGE, BAND_NOISE} band_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [lbsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lbsm_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  lbsm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lbsm_pkg::out_item_t out_data;

  low_battery_shutdown_monitor uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  // predictor state and register copy
  lbsm_pkg::cfg_t shadow_cfg;
  logic [CNT_W-1:0] emer_left, boot_elapsed, low_left, warn_left;
  logic low_set, shut_set;

  lbsm_pkg::in_item_t tick_queue[$];
  lbsm_pkg::out_item_t predicted_status[$];

  bit gaps_on = 1'b1;
  int ticks_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int stops_seen = 0;
  int lows_seen = 0;
  int shutdowns_seen = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  function automatic lbsm_pkg::out_item_t advance_tick(input lbsm_pkg::in_item_t t);
    lbsm_pkg::out_item_t r;
    logic below_low;
    r = '0;
    below_low = t.vmain_sample < shadow_cfg.low_level;
    if (t.vmain_sample < shadow_cfg.emergency_level) begin
      if (emer_left != 0) begin
        emer_left = emer_left - 1'b1;
        if (emer_left == 0) r.stop_request = 1'b1;
      end
    end else begin
      emer_left = shadow_cfg.early_ticks;
      if (t.charger_present) begin
        shut_set = 1'b0;
        boot_elapsed = shadow_cfg.early_ticks;
        if (warn_left < shadow_cfg.warning_ticks) warn_left = warn_left + 1'b1;
        else if (low_left < shadow_cfg.low_voltage_ticks) low_left = low_left + 1'b1;
        else low_set = 1'b0;
      end else if (boot_elapsed < shadow_cfg.early_ticks) begin
        if (below_low) low_set = 1'b1;
        boot_elapsed = boot_elapsed + 1'b1;
      end else if (low_set) begin
        if (warn_left == 0) begin
          r.stop_request = 1'b1;
        end else begin
          warn_left = warn_left - 1'b1;
          if (warn_left < shadow_cfg.battery_shutdown_ticks) shut_set = 1'b1;
        end
      end else if (below_low) begin
        if (low_left != 0) low_left = low_left - 1'b1;
        if (low_left == 0) low_set = 1'b1;
      end else begin
        low_left = shadow_cfg.low_voltage_ticks;
        warn_left = shadow_cfg.warning_ticks;
      end
    end
    if (t.robot_unpowered) boot_elapsed = '0;
    if (t.battery_full_clear) low_set = 1'b0;
    r.battery_low = low_set;
    r.battery_shutdown = shut_set;
    return r;
  endfunction

  function automatic lbsm_pkg::in_item_t make_tick(input logic [lbsm_pkg::LEVEL_W-1:0] v,
                                                   input bit chg, input bit unp,
                                                   input bit full);
    lbsm_pkg::in_item_t t;
    t.vmain_sample = v;
    t.charger_present = chg;
    t.robot_unpowered = unp;
    t.battery_full_clear = full;
    return t;
  endfunction

  function automatic logic [lbsm_pkg::LEVEL_W-1:0] volts_in(input band_t b);
    int unsigned e, l, top;
    logic [lbsm_pkg::LEVEL_W-1:0] v;
    e = shadow_cfg.emergency_level;
    l = shadow_cfg.low_level;
    top = (e > l) ? e : l;
    case (b)
      BAND_EMERG: begin
        if (e == 0) v = lbsm_pkg::LEVEL_W'($urandom_range(65535, 0));
        else v = lbsm_pkg::LEVEL_W'($urandom_range(e - 1, 0));
      end
      BAND_LOW: begin
        if (l > e) v = lbsm_pkg::LEVEL_W'($urandom_range(l - 1, e));
        else v = lbsm_pkg::LEVEL_W'($urandom_range(65535, top));
      end
      BAND_OK: v = lbsm_pkg::LEVEL_W'($urandom_range(65535, top));
      default: v = lbsm_pkg::LEVEL_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic write_reg(input lbsm_pkg::cfg_idx_t idx,
                           input logic [lbsm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    case (idx)
      lbsm_pkg::REG_EMERGENCY_LEVEL:
        shadow_cfg.emergency_level = val[lbsm_pkg::LEVEL_W-1:0];
      lbsm_pkg::REG_LOW_LEVEL:
        shadow_cfg.low_level = val[lbsm_pkg::LEVEL_W-1:0];
      lbsm_pkg::REG_LOW_VOLTAGE_TICKS:      shadow_cfg.low_voltage_ticks = val;
      lbsm_pkg::REG_EARLY_TICKS:            shadow_cfg.early_ticks = val;
      lbsm_pkg::REG_BATTERY_SHUTDOWN_TICKS: shadow_cfg.battery_shutdown_ticks = val;
      default:                              shadow_cfg.warning_ticks = val;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input int unsigned emer, input int unsigned low,
                            input int unsigned lv, input int unsigned early,
                            input int unsigned bs, input int unsigned warn);
    write_reg(lbsm_pkg::REG_EMERGENCY_LEVEL, lbsm_pkg::CFG_DATA_W'(emer));
    write_reg(lbsm_pkg::REG_LOW_LEVEL, lbsm_pkg::CFG_DATA_W'(low));
    write_reg(lbsm_pkg::REG_LOW_VOLTAGE_TICKS, lbsm_pkg::CFG_DATA_W'(lv));
    write_reg(lbsm_pkg::REG_EARLY_TICKS, lbsm_pkg::CFG_DATA_W'(early));
    write_reg(lbsm_pkg::REG_BATTERY_SHUTDOWN_TICKS, lbsm_pkg::CFG_DATA_W'(bs));
    write_reg(lbsm_pkg::REG_WARNING_TICKS, lbsm_pkg::CFG_DATA_W'(warn));
    settings_used++;
  endtask

  // bursts of one voltage band so counters run down; one band in five is raw noise
  task automatic queue_random(input int count);
    int n, len;
    band_t band;
    lbsm_pkg::in_item_t t;
    n = 0;
    while (n < count) begin
      band = band_t'($urandom_range(4, 0));
      len = $urandom_range(30, 3);
      repeat (len) begin
        if (band == BAND_NOISE) begin
          t = lbsm_pkg::in_item_t'($urandom);
        end else begin
          if (band == BAND_CHARGE)
            t.vmain_sample = volts_in($urandom_range(1, 0) ? BAND_LOW : BAND_OK);
          else
            t.vmain_sample = volts_in(band);
          t.charger_present = (band == BAND_CHARGE);
          t.robot_unpowered = ($urandom_range(99, 0) < 4);
          t.battery_full_clear = ($urandom_range(99, 0) < 4);
        end
        tick_queue.push_back(t);
        n++;
      end
    end
  endtask

  task automatic wait_idle;
    while (tick_queue.size() != 0 || in_valid || predicted_status.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // driver: predicts each transfer as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      shadow_cfg.emergency_level = lbsm_pkg::EMERGENCY_LEVEL_RST;
      shadow_cfg.low_level = lbsm_pkg::LOW_LEVEL_RST;
      shadow_cfg.low_voltage_ticks = lbsm_pkg::LOW_VOLTAGE_TICKS_RST;
      shadow_cfg.early_ticks = lbsm_pkg::EARLY_TICKS_RST;
      shadow_cfg.battery_shutdown_ticks = lbsm_pkg::BATTERY_SHUTDOWN_TICKS_RST;
      shadow_cfg.warning_ticks = lbsm_pkg::WARNING_TICKS_RST;
      emer_left = lbsm_pkg::EARLY_TICKS_RST;
      boot_elapsed = '0;
      low_left = lbsm_pkg::LOW_VOLTAGE_TICKS_RST;
      warn_left = lbsm_pkg::WARNING_TICKS_RST;
      low_set = 1'b0;
      shut_set = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_status.push_back(advance_tick(in_data));
        ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() != 0 && !(gaps_on && $urandom_range(99, 0) < 21)) begin
          in_valid <= 1'b1;
          in_data <= tick_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : result_check
    lbsm_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (out_data.stop_request) stops_seen++;
        if (out_data.battery_low) lows_seen++;
        if (out_data.battery_shutdown) shutdowns_seen++;
        if (predicted_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: stop=%0b low=%0b shut=%0b", out_data.stop_request,
                     out_data.battery_low, out_data.battery_shutdown);
        end else begin
          want = predicted_status.pop_front();
          if (out_data.stop_request !== want.stop_request ||
              out_data.battery_low !== want.battery_low ||
              out_data.battery_shutdown !== want.battery_shutdown) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected stop=%0b low=%0b shut=%0b, got %0b %0b %0b",
                       results_checked, want.stop_request, want.battery_low,
                       want.battery_shutdown, out_data.stop_request, out_data.battery_low,
                       out_data.battery_shutdown);
          end
        end
      end
      out_stall <= gaps_on && ($urandom_range(99, 0) < 21);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: field extremes and level boundaries
    tick_queue.push_back(make_tick(16'd0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'hFFFF, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b0, 1'b0, 1'b1));
    tick_queue.push_back(make_tick(16'd2487, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2486, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2647, 1'b0, 1'b1, 1'b0));
    tick_queue.push_back(make_tick(16'd2648, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2600, 1'b1, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'hFFFF, 1'b1, 1'b1, 1'b1));
    tick_queue.push_back(make_tick(16'd0, 1'b1, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'h5555, 1'b0, 1'b1, 1'b1));
    tick_queue.push_back(make_tick(16'hAAAA, 1'b1, 1'b0, 1'b0));
    wait_idle();

    // shortest counters: filter at zero, timer exhausted, warning at zero, top-up
    set_config(2000, 3000, 1, 1, 1, 1);
    tick_queue.push_back(make_tick(16'd2500, 1'b1, 1'b1, 1'b0));
    tick_queue.push_back(make_tick(16'd3500, 1'b0, 1'b0, 1'b1));
    tick_queue.push_back(make_tick(16'd3500, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b1, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b1, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b1, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(16'd2500, 1'b0, 1'b1, 1'b1));
    queue_random(80);
    wait_idle();

    set_config(65535, 65535, $urandom_range(40, 1), $urandom_range(20, 1),
               $urandom_range(30, 1), $urandom_range(40, 1));
    queue_random(90);
    wait_idle();

    set_config(0, 0, $urandom_range(40, 1), $urandom_range(20, 1),
               $urandom_range(30, 1), $urandom_range(40, 1));
    queue_random(90);
    wait_idle();

    set_config($urandom_range(4000, 1000), $urandom_range(4000, 1000),
               TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
    queue_random(90);
    wait_idle();

    for (int k = 0; k < 4; k++) begin
      set_config($urandom_range(4000, 1000), $urandom_range(4000, 1000),
                 $urandom_range(40, 1), $urandom_range(20, 1),
                 $urandom_range(30, 1), $urandom_range(40, 1));
      if (k == 1) gaps_on = 1'b0;
      queue_random(90);
      wait_idle();
      gaps_on = 1'b1;
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d ticks under %0d register settings plus reset values",
             ticks_sent, settings_used);
    $display("%0d results checked: %0d stop requests, %0d low, %0d shutdown",
             results_checked, stops_seen, lows_seen, shutdowns_seen);
    if (mismatches == 0 && predicted_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, predicted_status.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
